// File: design/bab_pkg.sv
// Package for the batch average brightness map block.
// Holds the transaction payload types, the batch record type and the fixed mapping constants.
// Depends on nothing; every other design file imports it.
package bab_pkg;

    typedef struct packed {
        logic [11:0] sample_value;
        logic        has_sample;
        logic        batch_end;
    } in_item_t;

    typedef struct packed {
        logic [11:0] average_value;
        logic [6:0]  level_pct;
        logic [7:0]  duty_value;
        logic        batch_overflow;
    } out_item_t;

    // One closed batch as handed from the accumulator to the mapping engine.
    typedef struct packed {
        logic [21:0] sum;
        logic [10:0] count;
        logic        overflow;
    } batch_t;

    localparam int SUM_W   = 22;
    localparam int COUNT_W = 11;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [11:0] FULL_SCALE = 12'd4095;
    localparam logic [6:0]  PCT_MIN    = 7'd50;
    localparam logic [6:0]  PCT_MAX    = 7'd100;

    // pct = floor((140*F^3 + 35*F^2*d + 15*d^3) / (2*F^3)) with F = 4095, d = 2*avg - F.
    localparam int          MAP_W       = 45;
    localparam int          PCT_QBITS   = 7;
    localparam logic [44:0] MAP_BASE    = 45'd9613682032500;
    localparam logic signed [30:0] MAP_LIN_K = 31'sd586915875;
    localparam logic [44:0] MAP_DIV     = 45'd137338314750;

    // The quotient by MAP_DIV is estimated as ((num >> 20) * floor(2^57 / MAP_DIV)) >> 37.
    // The estimate is never high and at most one low, so one compare against MAP_DIV fixes it.
    localparam int          MAP_DROP        = 20;
    localparam logic [20:0] MAP_RECIP       = 21'd1049344;
    localparam int          MAP_RECIP_SHIFT = 37;

    // duty = floor(pct*255/100) = (pct*255*5243) >> 19 for pct*255 up to 25500.
    localparam logic [13:0] DUTY_RECIP = 14'd5243;
    localparam int          DUTY_SHIFT = 19;

endpackage

// File: design/batch_average_brightness_map.sv
// Top level of the batch average brightness map block.
// Connects the accumulator front end, the batch queue and the mapping engine.
// Depends on bab_pkg, bab_front, bab_queue and bab_back.
//
//  Channel | Ports                      | Payload type       | Role
//  --------+----------------------------+--------------------+------------------------------
//  input   | s_valid, s_ready, s_data   | bab_pkg::in_item_t | samples and end-of-batch marks
//  result  | m_valid, m_ready, m_data   | bab_pkg::out_item_t| one transaction per non-empty batch
//
// The front end takes one input transaction every cycle while the batch queue has room.
// Each non-empty batch then passes through the mapping engine: it is taken from the queue,
// goes through the bit-serial sum/count division, the curve arithmetic, the reciprocal
// constant division that yields the percentage, and finally the duty.
// Reset is synchronous and active low; it empties the queue and clears the running batch.
// A stalled result channel holds the output register; the queue then absorbs up to
// four closed batches before s_ready falls.
module batch_average_brightness_map #(
    parameter int MAX_BATCH = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bab_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bab_pkg::out_item_t m_data
);
    import bab_pkg::*;

    // Closed batches travel from the accumulator to the mapping engine through the queue.
    logic   push_valid, push_ready;
    batch_t push_data;
    logic   pop_valid, pop_ready;
    batch_t pop_data;

    bab_front #(
        .MAX_BATCH (MAX_BATCH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    bab_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // The engine computes one batch at a time and holds its result until taken.
    bab_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: design/bab_front.sv
// Accumulator front end of the batch average brightness map block.
// Sums samples per batch and hands each non-empty closed batch to the queue.
// Depends on bab_pkg.
module bab_front #(
    parameter int MAX_BATCH = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bab_pkg::in_item_t s_data,
    output logic              push_valid,
    input  logic              push_ready,
    output bab_pkg::batch_t   push_data
);
    import bab_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_BATCH);

    logic [SUM_W-1:0]   sum_reg,   sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               ovf_reg,   ovf_next;
    logic [SUM_W-1:0]   sum_add;
    logic [COUNT_W-1:0] count_add;
    logic               ovf_add;
    logic               accept;

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        sum_add   = sum_reg;
        count_add = count_reg;
        ovf_add   = ovf_reg;
        if (s_data.has_sample) begin
            if (count_reg < MAX_COUNT) begin
                sum_add   = sum_reg + SUM_W'(s_data.sample_value);
                count_add = count_reg + COUNT_W'(1);
            end else begin
                ovf_add = 1'b1;
            end
        end
    end

    assign push_data.sum      = sum_add;
    assign push_data.count    = count_add;
    assign push_data.overflow = ovf_add;
    assign push_valid = accept && s_data.batch_end && (count_add != '0);

    always_comb begin
        sum_next   = sum_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept) begin
            if (s_data.batch_end) begin
                sum_next   = '0;
                count_next = '0;
                ovf_next   = 1'b0;
            end else begin
                sum_next   = sum_add;
                count_next = count_add;
                ovf_next   = ovf_add;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_COUNT)
        else $error("batch count exceeds the batch limit");
`endif

endmodule

// File: design/bab_queue.sv
// Short register queue of closed batches between the accumulator and the mapping engine.
// Depends on bab_pkg for the batch record type and the depth.
module bab_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  bab_pkg::batch_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output bab_pkg::batch_t pop_data
);
    import bab_pkg::*;

    batch_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   fill_reg,   fill_next;
    logic                   push, pop;

    assign push_ready = (fill_reg != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + (QUEUE_PTR_W+1)'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - (QUEUE_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue fill level out of range");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        QUEUE_PTR_W'(wr_ptr_reg - rd_ptr_reg) == fill_reg[QUEUE_PTR_W-1:0])
        else $error("queue pointers disagree with fill level");
`endif

endmodule

// File: design/bab_back.sv
// Mapping engine of the batch average brightness map block.
// Divides sum by count, evaluates the cubic brightness curve exactly, derives the duty,
// and holds the result in the output register. Depends on bab_pkg.
module bab_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  bab_pkg::batch_t    pop_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bab_pkg::out_item_t m_data
);
    import bab_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIV  = 4'd1;
    localparam logic [3:0] ST_AVG  = 4'd2;
    localparam logic [3:0] ST_SQ   = 4'd3;
    localparam logic [3:0] ST_CUBE = 4'd4;
    localparam logic [3:0] ST_SUM  = 4'd5;
    localparam logic [3:0] ST_QEST = 4'd6;
    localparam logic [3:0] ST_QFIX = 4'd7;
    localparam logic [3:0] ST_DUTY = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [4:0]          step_reg,  step_next;
    logic [COUNT_W-1:0]  rem_reg,   rem_next;
    logic [SUM_W-1:0]    quo_reg,   quo_next;
    logic [COUNT_W-1:0]  cnt_reg,   cnt_next;
    logic                ovf_reg,   ovf_next;
    logic [11:0]         avg_reg,   avg_next;
    logic signed [12:0]  d_reg,     d_next;
    logic [23:0]         sq_reg,    sq_next;
    logic signed [37:0]  cube_reg,  cube_next;
    logic signed [43:0]  lin_reg,   lin_next;
    logic [MAP_W-1:0]    num_reg,   num_next;
    logic [PCT_QBITS-1:0] q_reg,    q_next;
    out_item_t           out_reg,   out_next;
    logic                out_valid_reg, out_valid_next;

    logic [COUNT_W:0]    trial;
    logic                trial_ge;
    logic [11:0]         avg_clamped;
    logic signed [13:0]  d_wide;
    logic signed [25:0]  sq_full;
    logic signed [41:0]  cube15;
    logic signed [45:0]  num_signed;
    logic [MAP_W:0]      q_prod;
    logic [MAP_W-1:0]    q_mul;
    logic [MAP_W-1:0]    q_rem;
    logic                q_low;
    logic [6:0]          pct;
    logic [14:0]         pct255;
    logic [28:0]         duty_full;
    logic                out_free;

    assign pop_ready = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign out_free  = !out_valid_reg || m_ready;

    assign trial       = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_ge    = trial >= {1'b0, cnt_reg};
    assign avg_clamped = (quo_reg[SUM_W-1:12] != '0) ? FULL_SCALE : quo_reg[11:0];
    assign d_wide      = $signed({1'b0, avg_clamped, 1'b0}) - $signed({2'b00, FULL_SCALE});
    assign sq_full     = 26'(d_reg) * 26'(d_reg);
    assign cube15      = ($signed(42'(cube_reg)) <<< 4) - $signed(42'(cube_reg));
    assign num_signed  = $signed({1'b0, MAP_BASE}) + $signed(46'(lin_reg))
                       + $signed(46'(cube15));

    // The reciprocal estimate of the percentage, then the remainder that decides
    // whether it is one short.
    assign q_prod = (MAP_W+1)'(num_reg[MAP_W-1:MAP_DROP]) * (MAP_W+1)'(MAP_RECIP);
    assign q_mul  = MAP_W'(q_reg) * MAP_DIV;
    assign q_rem  = num_reg - q_mul;
    assign q_low  = q_rem >= MAP_DIV;

    always_comb begin
        if (q_reg < PCT_MIN) begin
            pct = PCT_MIN;
        end else if (q_reg > PCT_MAX) begin
            pct = PCT_MAX;
        end else begin
            pct = q_reg;
        end
    end

    assign pct255    = {pct, 8'd0} - 15'(pct);
    assign duty_full = 29'(pct255) * 29'(DUTY_RECIP);

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        avg_next       = avg_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        cube_next      = cube_reg;
        lin_next       = lin_reg;
        num_next       = num_reg;
        q_next         = q_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    quo_next   = pop_data.sum;
                    cnt_next   = pop_data.count;
                    ovf_next   = pop_data.overflow;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // Restoring division, one quotient bit per cycle.
                rem_next  = trial_ge ? COUNT_W'(trial - {1'b0, cnt_reg}) : trial[COUNT_W-1:0];
                quo_next  = {quo_reg[SUM_W-2:0], trial_ge};
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(SUM_W - 1)) begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG: begin
                avg_next   = avg_clamped;
                d_next     = d_wide[12:0];
                state_next = ST_SQ;
            end
            ST_SQ: begin
                sq_next    = sq_full[23:0];
                state_next = ST_CUBE;
            end
            ST_CUBE: begin
                cube_next  = 38'($signed({1'b0, sq_reg})) * 38'(d_reg);
                lin_next   = 44'(MAP_LIN_K) * 44'(d_reg);
                state_next = ST_SUM;
            end
            ST_SUM: begin
                num_next   = num_signed[45] ? '0 : num_signed[MAP_W-1:0];
                state_next = ST_QEST;
            end
            ST_QEST: begin
                q_next     = q_prod[MAP_RECIP_SHIFT+PCT_QBITS-1:MAP_RECIP_SHIFT];
                state_next = ST_QFIX;
            end
            ST_QFIX: begin
                if (q_low) begin
                    q_next = q_reg + PCT_QBITS'(1);
                end
                state_next = ST_DUTY;
            end
            ST_DUTY: begin
                if (out_free) begin
                    out_next.average_value  = avg_reg;
                    out_next.level_pct      = pct;
                    out_next.duty_value     = duty_full[DUTY_SHIFT+7:DUTY_SHIFT];
                    out_next.batch_overflow = ovf_reg;
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        ovf_reg  <= ovf_next;
        avg_reg  <= avg_next;
        d_reg    <= d_next;
        sq_reg   <= sq_next;
        cube_reg <= cube_next;
        lin_reg  <= lin_next;
        num_reg  <= num_next;
        q_reg    <= q_next;
        out_reg  <= out_next;
    end

`ifndef SYNTHESIS
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.level_pct >= PCT_MIN && m_data.level_pct <= PCT_MAX))
        else $error("brightness percentage out of range");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("pending result overwritten");
`endif

endmodule

// File: sim/batch_average_brightness_map_test.sv
// Self-checking testbench for the batch average brightness map block.
// Depends on bab_pkg for the payload types and on the batch_average_brightness_map RTL.
`timescale 1ns / 1ps

module batch_average_brightness_map_test;
    import bab_pkg::*;

    // The block is built with its largest batch size. The predictor uses the same limit.
    localparam int BATCH_LIMIT  = 1024;
    localparam int ADC_MAX      = 4095;
    localparam int DUTY_FULL    = 255;
    localparam int PCT_LOW      = 50;
    localparam int PCT_HIGH     = 100;
    localparam int IDLE_PERCENT = 22;
    // This is the length of the long result-side hold-off. It is long enough for the
    // queue of closed batches to fill and for s_ready to fall.
    localparam int HOLD_CYCLES  = 400;
    // These cycles pass after the last expected result, so a stray result is still caught.
    localparam int TAIL_CYCLES  = 96;
    // This limit allows many times the slowest correct run, with every item its own
    // batch and every stall.
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PRINT_CAP    = 30;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    batch_average_brightness_map #(
        .MAX_BATCH(BATCH_LIMIT)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // This is the predictor's copy of the batch being collected.
    logic [21:0] acc_sum     = '0;
    logic [10:0] acc_count   = '0;
    logic        acc_dropped = 1'b0;

    // These are the results still owed by the block, oldest first.
    out_item_t expected_batches[$];

    // These switches control the random idling on each side.
    bit sender_idle_on = 1'b1;
    bit result_idle_on = 1'b1;

    // The test process raises hold_requested. The result process serves it by
    // holding m_ready low for the HOLD_CYCLES hold-off, which it counts itself.
    int hold_requested = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    int error_count        = 0;
    int items_sent         = 0;
    int results_seen       = 0;
    int overflow_results   = 0;
    int empty_markers      = 0;
    int input_stall_cycles = 0;
    int cycle_count        = 0;

    // This is the brightness curve, evaluated exactly in 64-bit integers.
    // With d = 2*avg - 4095, pct = floor((140*F^3 + 35*d*F^2 + 15*d^3) / (2*F^3)),
    // and the result is then clamped to the legal percentage range.
    function automatic logic [6:0] brightness_of(input logic [11:0] avg);
        longint scale;
        longint scale3;
        longint a;
        longint d;
        longint num;
        longint q;
        scale  = ADC_MAX;
        scale3 = scale * scale * scale;
        a      = avg;
        d      = 2 * a - scale;
        num    = 140 * scale3 + 35 * d * scale * scale + 15 * d * d * d;
        if (num < 0) begin
            num = 0;
        end
        q = num / (2 * scale3);
        if (q < PCT_LOW) begin
            q = PCT_LOW;
        end
        if (q > PCT_HIGH) begin
            q = PCT_HIGH;
        end
        return q[6:0];
    endfunction

    // This function applies one accepted input transaction to the predictor. When the
    // transaction closes a batch that holds samples, it queues the expected result.
    function automatic void apply_item(input in_item_t item);
        out_item_t   want;
        int unsigned quotient;
        int unsigned pct;
        // A sample is counted first. When the batch is already full, the sample is
        // dropped and the batch is marked as overflowed.
        if (item.has_sample) begin
            if (acc_count < BATCH_LIMIT) begin
                acc_sum   = acc_sum + 22'(item.sample_value);
                acc_count = acc_count + 11'(1);
            end else begin
                acc_dropped = 1'b1;
            end
        end
        if (item.batch_end) begin
            if (acc_count != 0) begin
                quotient = 32'(acc_sum / acc_count);
                if (quotient > ADC_MAX) begin
                    quotient = ADC_MAX;
                end
                pct                  = 32'(brightness_of(quotient[11:0]));
                want.average_value   = quotient[11:0];
                want.level_pct       = pct[6:0];
                want.duty_value      = 8'((pct * DUTY_FULL) / PCT_HIGH);
                want.batch_overflow  = acc_dropped;
                expected_batches.push_back(want);
            end else begin
                empty_markers++;
            end
            acc_sum     = '0;
            acc_count   = '0;
            acc_dropped = 1'b0;
        end
    endfunction

    function automatic in_item_t make_item(input int value, input bit has, input bit last);
        in_item_t item;
        item.sample_value = value[11:0];
        item.has_sample   = has;
        item.batch_end    = last;
        return item;
    endfunction

    // This function returns a sample near the center, kept inside the 12-bit range.
    function automatic int sample_near(input int center, input int spread);
        int v;
        v = center - spread + int'($urandom_range(2 * spread));
        if (v < 0) begin
            v = 0;
        end
        if (v > ADC_MAX) begin
            v = ADC_MAX;
        end
        return v;
    endfunction

    task automatic flag_mismatch(input string what);
        if (error_count < PRINT_CAP) begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
        error_count++;
    endtask

    // This task offers one transaction and returns at the edge where it is accepted.
    // It lowers s_valid only in an idle cycle, so a transaction that follows right after
    // another one keeps valid high without a second assignment in the same step.
    task automatic send_item(input in_item_t item);
        while (sender_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) begin
            input_stall_cycles++;
            @(posedge aclk);
        end
        apply_item(item);
        items_sent++;
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (expected_batches.size() == 0) begin
            flag_mismatch($sformatf("result with no batch pending: avg %0d pct %0d duty %0d ovf %0b",
                got.average_value, got.level_pct, got.duty_value, got.batch_overflow));
            return;
        end
        want = expected_batches.pop_front();
        results_seen++;
        if (want.batch_overflow) begin
            overflow_results++;
        end
        if (got.average_value !== want.average_value) begin
            flag_mismatch($sformatf("average_value %0d, expected %0d",
                got.average_value, want.average_value));
        end
        if (got.level_pct !== want.level_pct) begin
            flag_mismatch($sformatf("level_pct %0d, expected %0d (avg %0d)",
                got.level_pct, want.level_pct, want.average_value));
        end
        if (got.duty_value !== want.duty_value) begin
            flag_mismatch($sformatf("duty_value %0d, expected %0d (avg %0d)",
                got.duty_value, want.duty_value, want.average_value));
        end
        if (got.batch_overflow !== want.batch_overflow) begin
            flag_mismatch($sformatf("batch_overflow %0b, expected %0b (avg %0d)",
                got.batch_overflow, want.batch_overflow, want.average_value));
        end
    endtask

    // This is the result side. At each edge it checks any accepted transaction, using
    // the value of m_ready from before the edge, and then picks the next m_ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_result(m_data);
        end
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requested) begin
            hold_served <= hold_requested;
            hold_left   <= HOLD_CYCLES - 1;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= !(result_idle_on && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    // This watchdog ends a run that hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // This task sends one well-formed batch with random content. The samples cluster
    // around a random center, so short and long batches give averages over the whole
    // range. The batch ends on its last sample or with a separate marker.
    task automatic send_random_batch();
        int len;
        int center;
        int spread;
        int style;
        int r;
        r      = $urandom_range(99);
        len    = (r < 70) ? $urandom_range(1, 8) :
                 (r < 95) ? $urandom_range(9, 64) : $urandom_range(65, 200);
        center = $urandom_range(ADC_MAX);
        spread = $urandom_range(1) ? $urandom_range(ADC_MAX) : $urandom_range(64);
        style  = $urandom_range(2);
        for (int i = 0; i < len; i++) begin
            // Sometimes a transaction that carries nothing falls inside the batch.
            if ($urandom_range(99) < 6) begin
                send_item(make_item($urandom_range(ADC_MAX), 1'b0, 1'b0));
            end
            send_item(make_item(sample_near(center, spread), 1'b1,
                                style == 0 && i == len - 1));
        end
        if (style != 0) begin
            // When the marker comes alone, its sample_value must be ignored.
            send_item(make_item(style == 2 ? $urandom_range(ADC_MAX) : 0, 1'b0, 1'b1));
        end
    endtask

    // These are hand-picked cases: the ends of the sample range, the midpoint, the lower
    // clamp, empty batches, a marker without a sample, and a marker that carries a sample.
    task automatic test_directed_cases();
        send_item(make_item(0, 1'b1, 1'b1));
        send_item(make_item(ADC_MAX, 1'b1, 1'b1));
        send_item(make_item(2047, 1'b1, 1'b1));
        send_item(make_item(2048, 1'b1, 1'b1));
        send_item(make_item(0, 1'b0, 1'b1));
        send_item(make_item(ADC_MAX, 1'b0, 1'b1));
        send_item(make_item(100, 1'b1, 1'b0));
        send_item(make_item(200, 1'b1, 1'b0));
        send_item(make_item(ADC_MAX, 1'b0, 1'b1));
        send_item(make_item(3, 1'b1, 1'b0));
        send_item(make_item(ADC_MAX, 1'b0, 1'b0));
        send_item(make_item(4, 1'b1, 1'b1));
        send_item(make_item(1, 1'b1, 1'b0));
        send_item(make_item(4094, 1'b1, 1'b1));
        send_item(make_item(200, 1'b1, 1'b1));
        send_item(make_item(300, 1'b1, 1'b1));
        send_item(make_item(500, 1'b1, 1'b1));
        send_item(make_item(1200, 1'b1, 1'b1));
        send_item(make_item(3000, 1'b1, 1'b1));
        send_item(make_item(3600, 1'b1, 1'b0));
        send_item(make_item(0, 1'b0, 1'b1));
        send_item(make_item(ADC_MAX, 1'b1, 1'b0));
        send_item(make_item(ADC_MAX, 1'b1, 1'b1));
    endtask

    // This task sends random traffic. Most of it is whole batches. The rest is empty
    // markers and transactions that carry nothing.
    task automatic test_random_batches(input int budget);
        int first;
        int pick;
        first = items_sent;
        while (items_sent - first < budget) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_item(make_item($urandom_range(ADC_MAX), 1'b0, 1'b0));
            end else if (pick < 13) begin
                send_item(make_item($urandom_range(ADC_MAX), 1'b0, 1'b1));
            end else begin
                send_random_batch();
            end
        end
    endtask

    // This task turns off idling on both sides for a long run of random traffic.
    task automatic test_back_to_back(input int budget);
        sender_idle_on = 1'b0;
        result_idle_on = 1'b0;
        test_random_batches(budget);
        sender_idle_on = 1'b1;
        result_idle_on = 1'b1;
    endtask

    // The result side holds off for a long stretch while one-sample batches keep coming.
    // The queue of closed batches fills and the input stalls until the hold-off ends.
    task automatic test_result_backpressure();
        sender_idle_on = 1'b0;
        hold_requested <= hold_requested + 1;
        for (int i = 0; i < 24; i++) begin
            send_item(make_item($urandom_range(ADC_MAX), 1'b1, 1'b1));
        end
        sender_idle_on = 1'b1;
    endtask

    // This test fills one batch to the limit with full-scale samples, which gives the
    // largest possible sum. It then offers more samples, which are dropped, and closes
    // the batch with a marker whose sample is dropped too. The batch after it must
    // report no overflow.
    task automatic test_batch_overflow();
        for (int i = 0; i < BATCH_LIMIT; i++) begin
            send_item(make_item(ADC_MAX, 1'b1, 1'b0));
        end
        send_item(make_item($urandom_range(ADC_MAX), 1'b1, 1'b0));
        send_item(make_item(0, 1'b1, 1'b0));
        send_item(make_item(0, 1'b1, 1'b1));
        send_item(make_item(7, 1'b1, 1'b1));
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_random_batches(580);
        test_back_to_back(290);
        test_result_backpressure();
        test_batch_overflow();
        s_valid <= 1'b0;

        // The run drains every owed result, then watches for stray results.
        while (expected_batches.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d input transactions, %0d batch results (%0d with overflow),",
            items_sent, results_seen, overflow_results);
        $display("%0d empty markers and %0d cycles of input stall.",
            empty_markers, input_stall_cycles);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: files.f
design/bab_pkg.sv
design/bab_front.sv
design/bab_queue.sv
design/bab_back.sv
design/batch_average_brightness_map.sv
sim/batch_average_brightness_map_test.sv
